// ===== design/osg_pkg.sv =====
// Shared constants, types and Horner coefficients for the octant sphere grid unit.
package osg_pkg;

    localparam int DEF_FRAC_BITS  = 16;
    localparam int DEF_INDEX_BITS = 12;
    localparam int QUEUE_DEPTH    = 2;

    localparam int CFG_W   = 12;
    localparam int STEP_W  = 12;
    localparam int FIELD_W = 17;

    localparam logic [CFG_W-1:0] GRID_RESET = 12'd64;

    // Q31 angle and series arithmetic
    localparam int QX_W  = 32;
    localparam int X2_W  = 33;
    localparam int V_W   = 32;
    localparam int T_W   = 34;
    localparam int RCP_SHIFT = 34;

    localparam logic [31:0] HALF_PI_Q31 = 32'hC90F_DAA2;
    localparam logic [31:0] Q31_ONE     = 32'h8000_0000;
    localparam logic [31:0] Q31_HALF    = 32'h4000_0000;

    localparam int NUM_SIN = 6;
    localparam int NUM_COS = 7;

    localparam logic [7:0] SIN_DIVS [NUM_SIN] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [7:0] COS_DIVS [NUM_COS] =
        '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

    // floor(2^34 / k) for each divisor
    localparam logic [T_W-1:0] SIN_RECIP [NUM_SIN] = '{
        34'd110127366, 34'd156180628, 34'd238609294,
        34'd409044504, 34'd858993459, 34'd2863311530};
    localparam logic [T_W-1:0] COS_RECIP [NUM_COS] = '{
        34'd94394885, 34'd130150524, 34'd190887435, 34'd306783378,
        34'd572662306, 34'd1431655765, 34'd8589934592};

    typedef enum logic [1:0] {
        PT_NORMAL,
        PT_POLE,
        PT_OUTSIDE
    } pt_class_t;

endpackage

// ===== design/osg_delay.sv =====
// Fixed-length shift register for aligning pipeline lanes.
module osg_delay #(
    parameter int W = 1,
    parameter int L = 1
) (
    input  logic         clk,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    if (L == 0)
    begin : g_pass
        assign q = d;
    end
    else
    begin : g_shift
        logic [W-1:0] sr_reg [L];

        always_ff @(posedge clk)
        begin
            sr_reg[0] <= d;
            for (int k = 1; k < L; k++)
            begin
                sr_reg[k] <= sr_reg[k-1];
            end
        end

        assign q = sr_reg[L-1];
    end

endmodule

// ===== design/osg_queue.sv =====
// Short FIFO between the classifying front and the arithmetic back.
module osg_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         full,
    output logic         empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= wdata;
        end
    end

endmodule

// ===== design/osg_front.sv =====
// Front end: register file, transaction acceptance and grid point classification.
module osg_front #(
    parameter int INDEX_BITS = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           cfg_write,
    input  logic [osg_pkg::CFG_W-1:0]      cfg_data,
    input  logic [osg_pkg::STEP_W-1:0]     polar_step,
    input  logic [osg_pkg::STEP_W-1:0]     azimuth_step,
    input  logic                           full,
    output logic                           push,
    output osg_pkg::pt_class_t             out_cls,
    output logic [INDEX_BITS-1:0]          out_j,
    output logic [INDEX_BITS-1:0]          out_i,
    output logic [INDEX_BITS-1:0]          out_nt,
    output logic [INDEX_BITS-1:0]          out_d
);

    import osg_pkg::*;

    localparam int IB = INDEX_BITS;

    logic [CFG_W-1:0] grid_reg;
    logic             fv_reg, fv_next;
    pt_class_t        cls_reg, cls_next;
    logic [IB-1:0]    j_reg, i_reg, nt_reg, d_reg;
    logic [IB-1:0]    j_in, i_in, nt_in, d_in;
    logic             accept;

    assign j_in   = IB'(polar_step);
    assign i_in   = IB'(azimuth_step);
    assign nt_in  = IB'(grid_reg);
    assign d_in   = nt_in - j_in;
    assign busy   = fv_reg & full;
    assign accept = start & ~busy;
    assign push   = fv_reg & ~full;

    always_comb
    begin
        priority if (j_in > nt_in)
        begin
            cls_next = PT_OUTSIDE;
        end
        else if (i_in > d_in)
        begin
            cls_next = PT_OUTSIDE;
        end
        else if (j_in == nt_in)
        begin
            cls_next = PT_POLE;
        end
        else
        begin
            cls_next = PT_NORMAL;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            fv_next = 1'b1;
        end
        else if (push)
        begin
            fv_next = 1'b0;
        end
        else
        begin
            fv_next = fv_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg <= GRID_RESET;
            fv_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                grid_reg <= cfg_data;
            end
            fv_reg <= fv_next;
        end
    end

    // hold the transaction until the queue has room
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cls_reg <= cls_next;
            j_reg   <= j_in;
            i_reg   <= i_in;
            nt_reg  <= nt_in;
            d_reg   <= d_in;
        end
    end

    assign out_cls = cls_reg;
    assign out_j   = j_reg;
    assign out_i   = i_reg;
    assign out_nt  = nt_reg;
    assign out_d   = d_reg;

endmodule

// ===== design/osg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module osg_div #(
    parameter int NW = 8,
    parameter int DW = 4,
    parameter int QW = 4
) (
    input  logic          clk,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    logic [NW-1:0] num_reg [QW];
    logic [NW-1:0] num_next [QW];
    logic [DW-1:0] den_reg [QW];
    logic [DW-1:0] den_next [QW];
    logic [DW-1:0] rem_reg [QW];
    logic [DW-1:0] rem_next [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [QW-1:0] quo_next [QW];

    always_comb
    begin
        logic [NW-1:0] n_in;
        logic [DW-1:0] d_in;
        logic [DW-1:0] r_in;
        logic [QW-1:0] q_in;
        logic [DW:0]   sh;
        logic [DW:0]   diff;
        logic          ge;
        for (int s = 0; s < QW; s++)
        begin
            if (s == 0)
            begin
                n_in = num;
                d_in = den;
                r_in = DW'(num >> QW);
                q_in = '0;
            end
            else
            begin
                n_in = num_reg[s-1];
                d_in = den_reg[s-1];
                r_in = rem_reg[s-1];
                q_in = quo_reg[s-1];
            end
            sh   = {r_in, n_in[QW-1-s]};
            ge   = (sh >= {1'b0, d_in});
            diff = sh - {1'b0, d_in};
            num_next[s] = n_in;
            den_next[s] = d_in;
            rem_next[s] = ge ? diff[DW-1:0] : sh[DW-1:0];
            quo_next[s] = {q_in[QW-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < QW; s++)
        begin
            num_reg[s] <= num_next[s];
            den_reg[s] <= den_next[s];
            rem_reg[s] <= rem_next[s];
            quo_reg[s] <= quo_next[s];
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

// ===== design/osg_sqrt.sv =====
// Pipelined digit-by-digit square root with round to nearest.
module osg_sqrt #(
    parameter int RW = 17
) (
    input  logic            clk,
    input  logic [2*RW-1:0] rad,
    output logic [RW-1:0]   root
);

    localparam int RMW = RW + 2;

    logic [2*RW-1:0] val_reg [RW];
    logic [2*RW-1:0] val_next [RW];
    logic [RW-1:0]   rt_reg [RW];
    logic [RW-1:0]   rt_next [RW];
    logic [RMW-1:0]  rm_reg [RW];
    logic [RMW-1:0]  rm_next [RW];
    logic [RW-1:0]   root_reg;

    always_comb
    begin
        logic [2*RW-1:0] v_in;
        logic [RW-1:0]   rt_in;
        logic [RMW-1:0]  rm_in;
        logic [RMW+1:0]  sh;
        logic [RMW+1:0]  trial;
        logic            ge;
        for (int s = 0; s < RW; s++)
        begin
            if (s == 0)
            begin
                v_in  = rad;
                rt_in = '0;
                rm_in = '0;
            end
            else
            begin
                v_in  = val_reg[s-1];
                rt_in = rt_reg[s-1];
                rm_in = rm_reg[s-1];
            end
            sh    = {rm_in, v_in[2*(RW-1-s) +: 2]};
            trial = (RMW+2)'({rt_in, 2'b01});
            ge    = (sh >= trial);
            val_next[s] = v_in;
            rm_next[s]  = ge ? RMW'(sh - trial) : RMW'(sh);
            rt_next[s]  = {rt_in[RW-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < RW; s++)
        begin
            val_reg[s] <= val_next[s];
            rt_reg[s]  <= rt_next[s];
            rm_reg[s]  <= rm_next[s];
        end
        // round up when the remainder exceeds the floor root
        root_reg <= rt_reg[RW-1] + RW'(rm_reg[RW-1] > RMW'(rt_reg[RW-1]));
    end

    assign root = root_reg;

endmodule

// ===== design/osg_horner.sv =====
// One Horner step of the Taylor series: v = 1 - round(x2 * v / k), clamped at zero.
module osg_horner #(
    parameter logic [7:0]  K = 8'd2,
    parameter logic [33:0] M = 34'd8589934592
) (
    input  logic                     clk,
    input  logic [osg_pkg::X2_W-1:0] x2_in,
    input  logic [osg_pkg::V_W-1:0]  v_in,
    output logic [osg_pkg::X2_W-1:0] x2_out,
    output logic [osg_pkg::V_W-1:0]  v_out
);

    import osg_pkg::*;

    logic [X2_W-1:0] x2a_reg, x2b_reg, x2c_reg;
    logic [T_W-1:0]  ta_reg, tb_reg, qe_reg;
    logic [V_W-1:0]  v_reg;
    logic [64:0]     prod;
    logic [67:0]     rprod;
    logic [T_W-1:0]  rem;
    logic [T_W-1:0]  quot;
    logic [V_W-1:0]  v_next;

    // fold the rounding of the 2^31 scale in before the constant divide
    assign prod  = 65'(x2_in) * 65'(v_in) + (65'(K) << 30);
    assign rprod = 68'(ta_reg) * 68'(M);
    assign rem   = tb_reg - T_W'(qe_reg * T_W'(K));
    assign quot  = qe_reg + T_W'(rem >= T_W'(K));

    always_comb
    begin
        if (quot >= T_W'(Q31_ONE))
        begin
            v_next = '0;
        end
        else
        begin
            v_next = V_W'(T_W'(Q31_ONE) - quot);
        end
    end

    always_ff @(posedge clk)
    begin
        ta_reg  <= T_W'(prod >> 31);
        x2a_reg <= x2_in;
        qe_reg  <= T_W'(rprod >> RCP_SHIFT);
        tb_reg  <= ta_reg;
        x2b_reg <= x2a_reg;
        v_reg   <= v_next;
        x2c_reg <= x2b_reg;
    end

    assign x2_out = x2c_reg;
    assign v_out  = v_reg;

endmodule

// ===== design/osg_back.sv =====
// Back end: polar and azimuth arithmetic lanes and the result register.
module osg_back #(
    parameter int FRAC_BITS  = 16,
    parameter int INDEX_BITS = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  osg_pkg::pt_class_t             in_cls,
    input  logic [INDEX_BITS-1:0]          in_j,
    input  logic [INDEX_BITS-1:0]          in_i,
    input  logic [INDEX_BITS-1:0]          in_nt,
    input  logic [INDEX_BITS-1:0]          in_d,
    output logic                           done,
    output logic [osg_pkg::FIELD_W-1:0]    cos_polar,
    output logic [osg_pkg::FIELD_W-1:0]    sin_polar,
    output logic [osg_pkg::FIELD_W-1:0]    cos_azimuth,
    output logic [osg_pkg::FIELD_W-1:0]    sin_azimuth,
    output logic                           index_error
);

    import osg_pkg::*;

    localparam int F        = FRAC_BITS;
    localparam int IB       = INDEX_BITS;
    localparam int RW       = F + 1;
    localparam int NWP      = 2 * IB + F + 1;
    localparam int NWX      = IB + QX_W + 1;
    localparam int SH       = 31 - F;
    localparam int POL_LAT  = 2 * F + 4;
    localparam int AZ_LAT   = QX_W + 1 + 3 * NUM_COS;
    localparam int SIN_LAT  = QX_W + 1 + 3 * NUM_SIN + 1;
    localparam int TOT      = (POL_LAT > AZ_LAT) ? POL_LAT : AZ_LAT;
    localparam int CLS_W    = $bits(pt_class_t);
    localparam logic [RW-1:0] ONE_F = RW'(1) << F;
    localparam logic [34:0]   RND   = 35'(1) << (SH - 1);

    // entry stage
    logic [TOT:0]     vld_reg;
    pt_class_t        cls_reg;
    logic [NWP-1:0]   cp_num_reg;
    logic [2*IB-1:0]  cp_den_reg;
    logic [NWX-1:0]   x_num_reg;
    logic [IB-1:0]    x_den_reg;
    logic [IB:0]      twice_less;
    logic [2*IB:0]    num_prod;
    logic [2*IB-1:0]  nt_sq;

    assign twice_less = {in_nt, 1'b0} - (IB+1)'(in_j);
    assign num_prod   = (2*IB+1)'(in_j) * (2*IB+1)'(twice_less);
    assign nt_sq      = (2*IB)'(in_nt) * (2*IB)'(in_nt);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[TOT-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg    <= in_cls;
        cp_num_reg <= (NWP'(num_prod) << F) + NWP'(nt_sq >> 1);
        cp_den_reg <= nt_sq;
        x_num_reg  <= NWX'(in_i) * NWX'(HALF_PI_Q31) + NWX'(in_d >> 1);
        x_den_reg  <= in_d;
    end

    // polar lane
    logic [RW-1:0]   cp_q;
    logic [RW-1:0]   cp_c;
    logic [RW-1:0]   cp_reg;
    logic [2*RW-1:0] rad_reg;
    logic [RW-1:0]   sp_root;

    osg_div #(.NW(NWP), .DW(2*IB), .QW(RW)) u_cp_div (
        .clk (clk),
        .num (cp_num_reg),
        .den (cp_den_reg),
        .quo (cp_q)
    );

    assign cp_c = (cp_q > ONE_F) ? ONE_F : cp_q;

    always_ff @(posedge clk)
    begin
        cp_reg  <= cp_c;
        rad_reg <= ((2*RW)'(1) << (2*F)) - (2*RW)'(cp_c) * (2*RW)'(cp_c);
    end

    osg_sqrt #(.RW(RW)) u_sqrt (
        .clk  (clk),
        .rad  (rad_reg),
        .root (sp_root)
    );

    // azimuth lane
    logic [QX_W-1:0] x_q;
    logic [QX_W-1:0] x_reg;
    logic [X2_W-1:0] x2_reg;
    logic [64:0]     x_sq;

    osg_div #(.NW(NWX), .DW(IB), .QW(QX_W)) u_x_div (
        .clk (clk),
        .num (x_num_reg),
        .den (x_den_reg),
        .quo (x_q)
    );

    assign x_sq = 65'(x_q) * 65'(x_q) + 65'(Q31_HALF);

    always_ff @(posedge clk)
    begin
        x_reg  <= x_q;
        x2_reg <= X2_W'(x_sq >> 31);
    end

    logic [X2_W-1:0] cx2 [NUM_COS+1];
    logic [V_W-1:0]  cv  [NUM_COS+1];
    logic [X2_W-1:0] sx2 [NUM_SIN+1];
    logic [V_W-1:0]  sv  [NUM_SIN+1];

    assign cx2[0] = x2_reg;
    assign cv[0]  = Q31_ONE;
    assign sx2[0] = x2_reg;
    assign sv[0]  = Q31_ONE;

    for (genvar g = 0; g < NUM_COS; g++)
    begin : g_cos
        osg_horner #(.K(COS_DIVS[g]), .M(COS_RECIP[g])) u_step (
            .clk    (clk),
            .x2_in  (cx2[g]),
            .v_in   (cv[g]),
            .x2_out (cx2[g+1]),
            .v_out  (cv[g+1])
        );
    end

    for (genvar g = 0; g < NUM_SIN; g++)
    begin : g_sin
        osg_horner #(.K(SIN_DIVS[g]), .M(SIN_RECIP[g])) u_step (
            .clk    (clk),
            .x2_in  (sx2[g]),
            .v_in   (sv[g]),
            .x2_out (sx2[g+1]),
            .v_out  (sv[g+1])
        );
    end

    logic [QX_W-1:0] x_dly;
    logic [64:0]     xv;
    logic [33:0]     sw_reg;

    osg_delay #(.W(QX_W), .L(3 * NUM_SIN)) u_x_dly (
        .clk (clk),
        .d   (x_reg),
        .q   (x_dly)
    );

    assign xv = 65'(x_dly) * 65'(sv[NUM_SIN]) + 65'(Q31_HALF);

    always_ff @(posedge clk)
    begin
        sw_reg <= 34'(xv >> 31);
    end

    // align every lane to the result stage
    logic [RW-1:0]    cp_al;
    logic [RW-1:0]    sp_al;
    logic [V_W-1:0]   ca_al;
    logic [33:0]      sw_al;
    logic [CLS_W-1:0] cls_al;

    osg_delay #(.W(RW), .L(TOT - F - 2)) u_cp_dly (
        .clk (clk), .d (cp_reg), .q (cp_al)
    );
    osg_delay #(.W(RW), .L(TOT - POL_LAT)) u_sp_dly (
        .clk (clk), .d (sp_root), .q (sp_al)
    );
    osg_delay #(.W(V_W), .L(TOT - AZ_LAT)) u_ca_dly (
        .clk (clk), .d (cv[NUM_COS]), .q (ca_al)
    );
    osg_delay #(.W(34), .L(TOT - SIN_LAT)) u_sa_dly (
        .clk (clk), .d (sw_reg), .q (sw_al)
    );
    osg_delay #(.W(CLS_W), .L(TOT)) u_cls_dly (
        .clk (clk), .d (cls_reg), .q (cls_al)
    );

    logic [34:0]        ca_frac;
    logic [34:0]        sa_frac;
    logic [FIELD_W-1:0] cp_o_next, sp_o_next, ca_o_next, sa_o_next;
    logic               err_next;
    logic [FIELD_W-1:0] cp_o_reg, sp_o_reg, ca_o_reg, sa_o_reg;
    logic               err_reg;
    logic               done_reg;

    assign ca_frac = (35'(ca_al) + RND) >> SH;
    assign sa_frac = (35'(sw_al) + RND) >> SH;

    always_comb
    begin
        unique case (pt_class_t'(cls_al))
            PT_NORMAL:
            begin
                cp_o_next = FIELD_W'(cp_al);
                sp_o_next = FIELD_W'(sp_al);
                ca_o_next = FIELD_W'(ca_frac);
                sa_o_next = FIELD_W'(sa_frac);
                err_next  = 1'b0;
            end
            PT_POLE:
            begin
                cp_o_next = FIELD_W'(ONE_F);
                sp_o_next = '0;
                ca_o_next = FIELD_W'(ONE_F);
                sa_o_next = '0;
                err_next  = 1'b0;
            end
            PT_OUTSIDE:
            begin
                cp_o_next = '0;
                sp_o_next = '0;
                ca_o_next = '0;
                sa_o_next = '0;
                err_next  = 1'b1;
            end
            default:
            begin
                cp_o_next = '0;
                sp_o_next = '0;
                ca_o_next = '0;
                sa_o_next = '0;
                err_next  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg[TOT];
        end
    end

    always_ff @(posedge clk)
    begin
        cp_o_reg <= cp_o_next;
        sp_o_reg <= sp_o_next;
        ca_o_reg <= ca_o_next;
        sa_o_reg <= sa_o_next;
        err_reg  <= err_next;
    end

    assign done        = done_reg;
    assign cos_polar   = cp_o_reg;
    assign sin_polar   = sp_o_reg;
    assign cos_azimuth = ca_o_reg;
    assign sin_azimuth = sa_o_reg;
    assign index_error = err_reg;

endmodule

// ===== design/octant_sphere_grid_angle_cos_sin_unit.sv =====
// Top level of the octant sphere grid angle cosine and sine unit.
//
// Usage: raise start with polar_step and azimuth_step; the transaction is taken
// at a clock edge where start is high and busy is low. Each transaction gives one
// result, shown for exactly one cycle with done high, on cos_polar, sin_polar,
// cos_azimuth, sin_azimuth and index_error. Results leave in acceptance order.
// A transaction passes the front register, the queue entry, the 32-stage azimuth
// divider followed by seven three-stage Horner steps, and the result register.
// Throughput: one transaction per cycle. The back end takes the queue head every
// cycle, so the queue never holds more than one entry and busy never rises.
// The receiver cannot stall results; it must sample done every cycle.
// The user must write grid_divisions with cfg_write and cfg_data only while the
// unit is idle; the block itself does not enforce this. Reset clears the pipeline
// valids and the queue and sets grid_divisions to 64.
module octant_sphere_grid_angle_cos_sin_unit #(
    parameter int FRAC_BITS  = osg_pkg::DEF_FRAC_BITS,
    parameter int INDEX_BITS = osg_pkg::DEF_INDEX_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        cfg_write,
    input  logic [osg_pkg::CFG_W-1:0]   cfg_data,
    input  logic [osg_pkg::STEP_W-1:0]  polar_step,
    input  logic [osg_pkg::STEP_W-1:0]  azimuth_step,
    output logic                        done,
    output logic [osg_pkg::FIELD_W-1:0] cos_polar,
    output logic [osg_pkg::FIELD_W-1:0] sin_polar,
    output logic [osg_pkg::FIELD_W-1:0] cos_azimuth,
    output logic [osg_pkg::FIELD_W-1:0] sin_azimuth,
    output logic                        index_error
);

    import osg_pkg::*;

    localparam int IB    = INDEX_BITS;
    localparam int CLS_W = $bits(pt_class_t);
    localparam int EW    = CLS_W + 4 * IB;

    logic          push, full, empty;
    pt_class_t     f_cls;
    logic [IB-1:0] f_j, f_i, f_nt, f_d;
    logic [EW-1:0] q_wdata, q_rdata;

    osg_front #(.INDEX_BITS(IB)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .polar_step   (polar_step),
        .azimuth_step (azimuth_step),
        .full         (full),
        .push         (push),
        .out_cls      (f_cls),
        .out_j        (f_j),
        .out_i        (f_i),
        .out_nt       (f_nt),
        .out_d        (f_d)
    );

    assign q_wdata = {f_cls, f_j, f_i, f_nt, f_d};

    // the back end drains one entry every cycle
    osg_queue #(.W(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (q_wdata),
        .pop   (!empty),
        .rdata (q_rdata),
        .full  (full),
        .empty (empty)
    );

    osg_back #(.FRAC_BITS(FRAC_BITS), .INDEX_BITS(IB)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (!empty),
        .in_cls      (pt_class_t'(q_rdata[EW-1 -: CLS_W])),
        .in_j        (q_rdata[4*IB-1 -: IB]),
        .in_i        (q_rdata[3*IB-1 -: IB]),
        .in_nt       (q_rdata[2*IB-1 -: IB]),
        .in_d        (q_rdata[IB-1:0]),
        .done        (done),
        .cos_polar   (cos_polar),
        .sin_polar   (sin_polar),
        .cos_azimuth (cos_azimuth),
        .sin_azimuth (sin_azimuth),
        .index_error (index_error)
    );

endmodule

// ===== tb/octant_sphere_grid_angle_cos_sin_checker.sv =====
// Checker for the octant sphere grid unit: predicts every accepted point and compares results.
module octant_sphere_grid_angle_cos_sin_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        cfg_write,
    input  logic [osg_pkg::CFG_W-1:0]   cfg_data,
    input  logic [osg_pkg::STEP_W-1:0]  polar_step,
    input  logic [osg_pkg::STEP_W-1:0]  azimuth_step,
    input  logic                        done,
    input  logic [osg_pkg::FIELD_W-1:0] cos_polar,
    input  logic [osg_pkg::FIELD_W-1:0] sin_polar,
    input  logic [osg_pkg::FIELD_W-1:0] cos_azimuth,
    input  logic [osg_pkg::FIELD_W-1:0] sin_azimuth,
    input  logic                        index_error,
    output int                          fail_count,
    output int                          pending
);
    import osg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [63:0] u64_t;

    typedef struct packed {
        logic [FIELD_W-1:0] cp;
        logic [FIELD_W-1:0] sp;
        logic [FIELD_W-1:0] ca;
        logic [FIELD_W-1:0] sa;
        logic               err;
    } angles_t;

    angles_t        angles_due[$];
    logic [CFG_W-1:0] divisions;

    function automatic u64_t sqrt_nearest(u64_t v);
        u64_t r, b, x;
        r = 0;
        b = u64_t'(1) << 62;
        x = v;
        while (b > x) b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        if (x > r) r++;
        return r;
    endfunction

    // One Horner step: 1 - round(x^2 * v / k), clamped at zero
    function automatic u64_t series_step(u64_t x2, u64_t v, u64_t k);
        u64_t den, m;
        den = k << 31;
        m = (x2 * v + (den >> 1)) / den;
        return (m >= u64_t'(Q31_ONE)) ? 0 : u64_t'(Q31_ONE) - m;
    endfunction

    function automatic angles_t grid_angles(u64_t nt, u64_t j, u64_t i);
        angles_t a;
        u64_t one, nt2, num, d, x, x2, v, cp;
        one = u64_t'(1) << DEF_FRAC_BITS;
        a = '0;
        if (j > nt || i > nt - j)
            a.err = 1'b1;
        else if (j == nt)
        begin
            if (i == 0)
            begin
                a.cp = FIELD_W'(one);
                a.ca = FIELD_W'(one);
            end
            else
                a.err = 1'b1;
        end
        else
        begin
            nt2 = nt * nt;
            num = j * (2 * nt - j);
            d = nt - j;
            cp = ((num << DEF_FRAC_BITS) + (nt2 >> 1)) / nt2;
            if (cp > one) cp = one;
            a.cp = FIELD_W'(cp);
            a.sp = FIELD_W'(sqrt_nearest((u64_t'(1) << (2 * DEF_FRAC_BITS)) - cp * cp));
            x = (i * u64_t'(HALF_PI_Q31) + (d >> 1)) / d;
            x2 = (x * x + (u64_t'(1) << 30)) >> 31;
            v = u64_t'(Q31_ONE);
            for (int k = 0; k < NUM_SIN; k++) v = series_step(x2, v, u64_t'(SIN_DIVS[k]));
            v = (x * v + (u64_t'(1) << 30)) >> 31;
            a.sa = FIELD_W'((v + (u64_t'(1) << (30 - DEF_FRAC_BITS))) >> (31 - DEF_FRAC_BITS));
            v = u64_t'(Q31_ONE);
            for (int k = 0; k < NUM_COS; k++) v = series_step(x2, v, u64_t'(COS_DIVS[k]));
            a.ca = FIELD_W'((v + (u64_t'(1) << (30 - DEF_FRAC_BITS))) >> (31 - DEF_FRAC_BITS));
        end
        return a;
    endfunction

    assign pending = angles_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        angles_t want, got;
        if (!rst_n)
        begin
            divisions  <= GRID_RESET;
            fail_count <= 0;
            angles_due.delete();
        end
        else
        begin
            if (cfg_write)
                divisions <= cfg_data;
            if (start && !busy)
                angles_due.push_back(grid_angles(u64_t'(divisions), u64_t'(polar_step),
                                                 u64_t'(azimuth_step)));
            if (done)
            begin
                got = '{cos_polar, sin_polar, cos_azimuth, sin_azimuth, index_error};
                if (angles_due.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result %h", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = angles_due.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                            $display({"mismatch: cp %0d/%0d sp %0d/%0d ca %0d/%0d",
                                      " sa %0d/%0d err %0d/%0d"},
                                     want.cp, got.cp, want.sp, got.sp, want.ca, got.ca,
                                     want.sa, got.sa, want.err, got.err);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/octant_sphere_grid_angle_cos_sin_unit_test.sv =====
// Testbench top for the octant sphere grid unit: stimulus, configuration phases and verdict.
module octant_sphere_grid_angle_cos_sin_unit_test;
    import osg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 70;
    localparam int CYCLE_LIMIT   = 300000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               cfg_write = 1'b0;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic [STEP_W-1:0]  polar_step = '0;
    logic [STEP_W-1:0]  azimuth_step = '0;
    logic               done;
    logic [FIELD_W-1:0] cos_polar, sin_polar, cos_azimuth, sin_azimuth;
    logic               index_error;
    int                 fail_count, pending;
    int                 cycles = 0;
    int                 divs;

    octant_sphere_grid_angle_cos_sin_unit dut (.*);
    octant_sphere_grid_angle_cos_sin_checker checker_i (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offer one grid point after a random gap; hold start until the transaction is taken
    task automatic send_point(int j, int i);
        int gap;
        bit taken;
        gap = $urandom_range(0, 9);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        polar_step   <= STEP_W'(j);
        azimuth_step <= STEP_W'(i);
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_divisions(int v);
        drain();
        cfg_write <= 1'b1;
        cfg_data  <= CFG_W'(v);
        @(posedge clk);
        cfg_write <= 1'b0;
        divs = v;
        @(posedge clk);
    endtask

    task automatic run_phase(int count);
        int j;
        // corners, pole, edges and points just outside the triangle
        send_point(0, 0);
        send_point(divs, 0);
        send_point(divs, 1);
        send_point(divs + 1, 0);
        send_point(0, divs);
        send_point(0, divs + 1);
        send_point(4095, 4095);
        send_point(4095, 0);
        send_point(0, 4095);
        if (divs > 0)
        begin
            send_point(divs - 1, 1);
            send_point(divs - 1, 0);
            send_point(divs / 2, divs - divs / 2);
        end
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                j = $urandom_range(0, divs);
                send_point(j, $urandom_range(0, divs - j));
            end
            else
                send_point($urandom_range(0, 4095), $urandom_range(0, 4095));
            if (n == count / 2)
                drain();
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        divs = int'(GRID_RESET);
        @(posedge clk);
        run_phase(200);
        set_divisions(1);
        run_phase(100);
        set_divisions(4095);
        run_phase(250);
        set_divisions(0);
        run_phase(60);
        set_divisions(2);
        run_phase(100);
        set_divisions(7);
        run_phase(150);
        set_divisions(2730);
        run_phase(150);
        set_divisions($urandom_range(1, 4095));
        run_phase(150);
        drain();
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== filelist.f =====
design/osg_pkg.sv
design/osg_delay.sv
design/osg_queue.sv
design/osg_front.sv
design/osg_div.sv
design/osg_sqrt.sv
design/osg_horner.sv
design/osg_back.sv
design/octant_sphere_grid_angle_cos_sin_unit.sv
tb/octant_sphere_grid_angle_cos_sin_checker.sv
tb/octant_sphere_grid_angle_cos_sin_unit_test.sv
